[src/mmf_pkg.sv]
// Shared types and constants for the MIDI message framer.
package mmf_pkg;

  localparam int DESC_BYTES           = 5;
  localparam int CNT_W                = $clog2(DESC_BYTES + 1);
  localparam int IDX_W                = $clog2(DESC_BYTES);
  localparam int MAX_NUMBER_BYTES_DEF = 5;
  localparam int QUEUE_DEPTH_DEF      = 2;

  localparam logic [7:0] STATUS_META  = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX = 8'hF0;
  localparam logic [7:0] VLQ_CONT     = 8'h80;
  localparam logic [7:0] VLQ_MASK     = 8'h7F;
  localparam logic [7:0] CHANNEL_MAX  = 8'h0F;

  typedef enum logic [2:0] {
    CMD_CHANNEL2 = 3'd0,
    CMD_CHANNEL3 = 3'd1,
    CMD_META     = 3'd2,
    CMD_SYSEX    = 3'd3,
    CMD_PAYLOAD  = 3'd4,
    CMD_NUMBER   = 3'd5
  } cmd_t;

  // One queued message fragment: bytes leave in index order.
  typedef struct packed {
    logic [DESC_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]           cnt;
    logic                       last;
    logic                       err;
  } desc_t;

  typedef struct packed {
    logic [DESC_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]           cnt;
  } vlq_t;

endpackage

[src/mmf_ifs.sv]
// Valid/ready channel interfaces for framer commands and output bytes.
interface mmf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  status;
  logic [7:0]  channel;
  logic [7:0]  data1;
  logic [7:0]  data2;
  logic [7:0]  meta_type;
  logic [7:0]  length;
  logic [7:0]  data_byte;
  logic [31:0] value;

  modport source (
    output valid, command, status, channel, data1, data2, meta_type, length,
           data_byte, value,
    input  ready
  );
  modport sink (
    input  valid, command, status, channel, data1, data2, meta_type, length,
           data_byte, value,
    output ready
  );
endinterface

interface mmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

[src/mmf_front.sv]
// Front end: accepts commands, tracks pending payload, builds byte descriptors.
module mmf_front
  import mmf_pkg::*;
#(
  parameter int MAX_NUMBER_BYTES = MAX_NUMBER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mmf_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_desc
);

  localparam int NUM_LIMIT = (MAX_NUMBER_BYTES < DESC_BYTES) ? MAX_NUMBER_BYTES : DESC_BYTES;

  logic [7:0] payload_left_r, payload_left_nxt;
  logic       accept;
  vlq_t       len_vlq, num_vlq;
  desc_t      err_desc;

  function automatic vlq_t vlq_encode(input logic [31:0] v);
    logic [DESC_BYTES*7-1:0]   ext;
    logic [DESC_BYTES-1:0][7:0] grp;
    logic [CNT_W-1:0]          g;
    vlq_t                      res;
    ext = (DESC_BYTES*7)'(v);
    g   = CNT_W'(1);
    for (int k = 0; k < DESC_BYTES; k++) begin
      grp[k] = {1'b0, ext[7*k +: 7]};
    end
    for (int k = 1; k < DESC_BYTES; k++) begin
      if ((ext >> (7*k)) != '0) g = CNT_W'(k + 1);
    end
    res.cnt = g;
    for (int j = 0; j < DESC_BYTES; j++) begin
      if (j < int'(g)) begin
        res.bytes[j] = grp[IDX_W'(int'(g) - 1 - j)] & VLQ_MASK;
        if (j < int'(g) - 1) res.bytes[j] = res.bytes[j] | VLQ_CONT;
      end else begin
        res.bytes[j] = '0;
      end
    end
    return res;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign len_vlq     = vlq_encode({24'd0, in_ch.length});
  assign num_vlq     = vlq_encode(in_ch.value);

  always_comb begin
    err_desc       = '0;
    err_desc.cnt   = CNT_W'(1);
    err_desc.last  = 1'b1;
    err_desc.err   = 1'b1;
  end

  always_comb begin
    q_desc           = '0;
    q_push           = 1'b0;
    payload_left_nxt = payload_left_r;
    case (in_ch.command)
      CMD_CHANNEL2, CMD_CHANNEL3: begin
        q_push = accept;
        if (payload_left_r != '0 || in_ch.channel > CHANNEL_MAX) begin
          q_desc = err_desc;
        end else begin
          q_desc.bytes[0] = in_ch.status | in_ch.channel;
          q_desc.bytes[1] = in_ch.data1;
          q_desc.bytes[2] = in_ch.data2;
          q_desc.cnt      = (in_ch.command == CMD_CHANNEL2) ? CNT_W'(2) : CNT_W'(3);
          q_desc.last     = 1'b1;
        end
      end
      CMD_META, CMD_SYSEX: begin
        q_push = accept;
        if (payload_left_r != '0) begin
          q_desc = err_desc;
        end else begin
          if (in_ch.command == CMD_META) begin
            q_desc.bytes[0] = STATUS_META;
            q_desc.bytes[1] = in_ch.meta_type;
            q_desc.bytes[2] = len_vlq.bytes[0];
            q_desc.bytes[3] = len_vlq.bytes[1];
            q_desc.cnt      = CNT_W'(2) + len_vlq.cnt;
          end else begin
            q_desc.bytes[0] = STATUS_SYSEX;
            q_desc.bytes[1] = len_vlq.bytes[0];
            q_desc.bytes[2] = len_vlq.bytes[1];
            q_desc.cnt      = CNT_W'(1) + len_vlq.cnt;
          end
          q_desc.last = (in_ch.length == '0);
          if (accept) payload_left_nxt = in_ch.length;
        end
      end
      CMD_PAYLOAD: begin
        q_push = accept;
        if (payload_left_r == '0) begin
          q_desc = err_desc;
        end else begin
          q_desc.bytes[0] = in_ch.data_byte;
          q_desc.cnt      = CNT_W'(1);
          q_desc.last     = (payload_left_r == 8'd1);
          if (accept) payload_left_nxt = payload_left_r - 8'd1;
        end
      end
      CMD_NUMBER: begin
        q_push = accept;
        if (int'(num_vlq.cnt) > NUM_LIMIT) begin
          q_desc = err_desc;
        end else begin
          q_desc.bytes = num_vlq.bytes;
          q_desc.cnt   = num_vlq.cnt;
          q_desc.last  = 1'b1;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_left_r <= '0;
    end else begin
      payload_left_r <= payload_left_nxt;
    end
  end

  // payload count only moves on an accepted header or payload item
  assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> payload_left_r == $past(payload_left_r))
    else $error("payload count changed without an accepted item");

endmodule

[src/mmf_queue.sv]
// Short descriptor queue between front end and byte serializer.
module mmf_queue
  import mmf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t head,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  desc_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

[src/mmf_back.sv]
// Back end: serializes queued descriptors into bytes, one per ready cycle.
module mmf_back
  import mmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  desc_t      head,
  input  logic       q_empty,
  output logic       q_pop,
  mmf_out_if.source  out_ch
);

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_err_r, out_err_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             load, final_byte;

  assign load       = !q_empty && (!out_valid_r || out_ch.ready);
  assign final_byte = (CNT_W'(idx_r) == head.cnt - CNT_W'(1));
  assign q_pop      = load && final_byte;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = head.bytes[idx_r];
      out_last_nxt  = final_byte && head.last;
      out_err_nxt   = head.err;
      idx_nxt       = final_byte ? '0 : idx_r + 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;
  assign out_ch.error    = out_err_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r && out_byte_r == '0)
    else $error("error item must be a zero byte with last set");
  assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> CNT_W'(idx_r) < head.cnt)
    else $error("byte index beyond descriptor length");

endmodule

[src/midi_message_framer_top.sv]
// Top level of the MIDI message framer.
// An accepted item is written into the descriptor queue, and its first byte then
// passes through the output register. Throughput: while out_ch.ready is high, the
// byte serializer sends one byte per cycle; payload items (one byte) sustain one
// item per cycle. The input stalls only while the descriptor queue is full.
// Reset (rst_n low, synchronous) clears the pending payload count, queue and output.
module midi_message_framer_top
  import mmf_pkg::*;
#(
  parameter int MAX_NUMBER_BYTES = MAX_NUMBER_BYTES_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mmf_in_if.sink    in_ch,
  mmf_out_if.source out_ch
);

  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_desc, q_head;

  mmf_front #(.MAX_NUMBER_BYTES(MAX_NUMBER_BYTES)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (q_desc)
  );

  mmf_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mmf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for the MIDI message framer: directed and random commands.
module tb;
  import mmf_pkg::*;

  localparam int NUM_BYTES_MAX = MAX_NUMBER_BYTES_DEF;
  localparam int ITEM_COUNT    = 380;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SQUEEZE_LEN   = 150;
  localparam int DRAIN_CYCLES  = 16;
  localparam int REPORT_CAP    = 100;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct {
    logic [2:0]  command;
    logic [7:0]  status;
    logic [7:0]  channel;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [7:0]  meta_type;
    logic [7:0]  length;
    logic [7:0]  data_byte;
    logic [31:0] value;
  } cmd_item_t;

  typedef struct {
    logic [7:0] octet;
    logic       last;
    logic       err;
  } octet_rec_t;

  class framer_scoreboard;
    octet_rec_t expected_bytes[$];
    logic [7:0] owed;
    int         fails;

    function new();
      owed  = '0;
      fails = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic l, logic e);
      octet_rec_t r;
      r.octet = b;
      r.last  = l;
      r.err   = e;
      expected_bytes.push_back(r);
    endfunction

    function int groups_of(logic [31:0] v);
      logic [63:0] v64;
      int g;
      v64 = {32'd0, v};
      g = 1;
      while (g < 6 && (v64 >> (7 * g)) != 0) g++;
      return g;
    endfunction

    function void push_vlq(logic [31:0] v, int g, logic mark_last);
      logic [63:0] v64;
      logic [7:0]  b;
      v64 = {32'd0, v};
      for (int k = g - 1; k >= 0; k--) begin
        b = {1'b0, v64[7*k +: 7]} & VLQ_MASK;
        if (k > 0) b = b | VLQ_CONT;
        push_byte(b, (k == 0) && mark_last, 1'b0);
      end
    endfunction

    // Expected bytes for one accepted command.
    function void note_command(cmd_item_t it);
      int g;
      case (it.command)
        CMD_CHANNEL2, CMD_CHANNEL3: begin
          if (owed != 0 || it.channel > CHANNEL_MAX) begin
            push_byte(8'h00, 1'b1, 1'b1);
          end else begin
            push_byte(it.status | it.channel, 1'b0, 1'b0);
            if (it.command == CMD_CHANNEL2) begin
              push_byte(it.data1, 1'b1, 1'b0);
            end else begin
              push_byte(it.data1, 1'b0, 1'b0);
              push_byte(it.data2, 1'b1, 1'b0);
            end
          end
        end
        CMD_META, CMD_SYSEX: begin
          if (owed != 0) begin
            push_byte(8'h00, 1'b1, 1'b1);
          end else begin
            if (it.command == CMD_META) begin
              push_byte(STATUS_META, 1'b0, 1'b0);
              push_byte(it.meta_type, 1'b0, 1'b0);
            end else begin
              push_byte(STATUS_SYSEX, 1'b0, 1'b0);
            end
            push_vlq({24'd0, it.length}, groups_of({24'd0, it.length}), it.length == 0);
            owed = it.length;
          end
        end
        CMD_PAYLOAD: begin
          if (owed == 0) begin
            push_byte(8'h00, 1'b1, 1'b1);
          end else begin
            owed = owed - 8'd1;
            push_byte(it.data_byte, owed == 0, 1'b0);
          end
        end
        CMD_NUMBER: begin
          g = groups_of(it.value);
          if (g > NUM_BYTES_MAX || g > 5) push_byte(8'h00, 1'b1, 1'b1);
          else push_vlq(it.value, g, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] b, logic l, logic e);
      octet_rec_t r;
      if (expected_bytes.size() == 0) begin
        if (fails < REPORT_CAP)
          $display("%0t: unexpected byte %h last %b error %b", $time, b, l, e);
        fails++;
        return;
      end
      r = expected_bytes.pop_front();
      if (b !== r.octet) begin
        if (fails < REPORT_CAP)
          $display("%0t: out_byte expected %h actual %h", $time, r.octet, b);
        fails++;
      end
      if (l !== r.last) begin
        if (fails < REPORT_CAP)
          $display("%0t: last expected %b actual %b", $time, r.last, l);
        fails++;
      end
      if (e !== r.err) begin
        if (fails < REPORT_CAP)
          $display("%0t: error expected %b actual %b", $time, r.err, e);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mmf_in_if  in_ch();
  mmf_out_if out_ch();

  framer_scoreboard sb = new();

  midi_message_framer_top #(
    .MAX_NUMBER_BYTES(NUM_BYTES_MAX)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic cmd_item_t make_item(logic [2:0] cmd);
    cmd_item_t it;
    it.command   = cmd;
    it.status    = 8'($urandom);
    it.channel   = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                                : 8'($urandom_range(16, 255));
    it.data1     = 8'($urandom);
    it.data2     = 8'($urandom);
    it.meta_type = 8'($urandom);
    it.length    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 6))
                 : ($urandom_range(0, 9) < 7)   ? 8'($urandom_range(7, 127))
                                                : 8'($urandom_range(128, 255));
    it.data_byte = 8'($urandom);
    it.value     = $urandom >> $urandom_range(0, 31);
    return it;
  endfunction

  task automatic send_item(input cmd_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= it.command;
    in_ch.status    <= it.status;
    in_ch.channel   <= it.channel;
    in_ch.data1     <= it.data1;
    in_ch.data2     <= it.data2;
    in_ch.meta_type <= it.meta_type;
    in_ch.length    <= it.length;
    in_ch.data_byte <= it.data_byte;
    in_ch.value     <= it.value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(it);
  endtask

  // output ready: random stalls plus one long hold-off
  initial begin
    int cyc;
    int n;
    int squeeze_at;
    bit squeezed;
    out_ch.ready <= 1'b0;
    squeeze_at = $urandom_range(200, 500);
    squeezed   = 1'b0;
    cyc        = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!squeezed && cyc >= squeeze_at) begin
        n = SQUEEZE_LEN;
        squeezed = 1'b1;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        cyc += n;
      end
      out_ch.ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      cyc += n;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_byte(out_ch.out_byte, out_ch.last, out_ch.error);
  end

  // watchdog: cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    cmd_item_t it;
    int sent;
    int r;
    logic [2:0] cmd;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= '0;
    in_ch.status    <= '0;
    in_ch.channel   <= '0;
    in_ch.data1     <= '0;
    in_ch.data2     <= '0;
    in_ch.meta_type <= '0;
    in_ch.length    <= '0;
    in_ch.data_byte <= '0;
    in_ch.value     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    it = make_item(CMD_CHANNEL2);
    it.status = 8'h90; it.channel = 8'd0; it.data1 = 8'h00; send_item(it);
    it = make_item(CMD_CHANNEL2);
    it.status = 8'h80; it.channel = 8'd15; it.data1 = 8'hFF; send_item(it);
    it = make_item(CMD_CHANNEL3);
    it.status = 8'hFF; it.channel = 8'd0; it.data1 = 8'h00; it.data2 = 8'hFF; send_item(it);
    it = make_item(CMD_CHANNEL3); it.channel = 8'd16; send_item(it);
    it = make_item(CMD_CHANNEL2); it.channel = 8'd255; send_item(it);
    it = make_item(CMD_META); it.meta_type = 8'h2F; it.length = 8'd0; send_item(it);
    it = make_item(CMD_META); it.meta_type = 8'h03; it.length = 8'd3; send_item(it);
    it = make_item(CMD_PAYLOAD); it.data_byte = 8'h00; send_item(it);
    it = make_item(CMD_CHANNEL2); it.channel = 8'd1; send_item(it);
    it = make_item(CMD_META); send_item(it);
    it = make_item(CMD_SYSEX); send_item(it);
    it = make_item(CMD_NUMBER); it.value = 32'h0FFF_FFFF; send_item(it);
    it = make_item(CMD_PAYLOAD); it.data_byte = 8'hFF; send_item(it);
    it = make_item(CMD_PAYLOAD); it.data_byte = 8'h5A; send_item(it);
    it = make_item(CMD_PAYLOAD); send_item(it);
    it = make_item(CMD_SYSEX); it.length = 8'd1; send_item(it);
    it = make_item(CMD_PAYLOAD); send_item(it);
    it = make_item(CMD_NUMBER); it.value = 32'd0; send_item(it);
    it = make_item(CMD_NUMBER); it.value = 32'd127; send_item(it);
    it = make_item(CMD_NUMBER); it.value = 32'd128; send_item(it);
    it = make_item(CMD_NUMBER); it.value = 32'h0000_4000; send_item(it);
    it = make_item(CMD_NUMBER); it.value = 32'hFFFF_FFFF; send_item(it);
    it = make_item(CMD_SPARE6); send_item(it);
    it = make_item(CMD_SPARE7); send_item(it);

    // random: one long message first, then mostly well-formed traffic with noise
    it = make_item(($urandom_range(0, 1) != 0) ? CMD_META : CMD_SYSEX);
    it.length = 8'($urandom_range(128, 255));
    send_item(it);
    sent = 1;
    while (sent < ITEM_COUNT) begin
      r = $urandom_range(0, 99);
      if (sb.owed != 0 && r < 85) begin
        cmd = CMD_PAYLOAD;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20)      cmd = CMD_CHANNEL2;
        else if (r < 40) cmd = CMD_CHANNEL3;
        else if (r < 55) cmd = CMD_META;
        else if (r < 70) cmd = CMD_SYSEX;
        else if (r < 90) cmd = CMD_NUMBER;
        else if (r < 95) cmd = CMD_PAYLOAD;
        else             cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
      end
      it = make_item(cmd);
      send_item(it);
      if (cmd != CMD_SPARE6 && cmd != CMD_SPARE7) sent++;
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
